>>> sv/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]   func;
        logic [31:0]  a_num;
        logic [31:0]  a_den;
        logic [31:0]  b_num;
        logic [31:0]  b_den;
    } in_item_t;

    typedef struct packed {
        logic [31:0]  res_num;
        logic [31:0]  res_den;
        logic         error;
    } out_item_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_REM
    } unit_op_t;

    typedef struct packed {
        logic      start;
        unit_op_t  op;
    } unit_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LD_A,
        ST_LD_B,
        ST_LD_FIX,
        ST_GCD_REM,
        ST_RED_DIVN,
        ST_RED_DIVD,
        ST_WB,
        ST_L_INIT,
        ST_L_MUL,
        ST_L_DIV,
        ST_T1_MUL,
        ST_T1_DIV,
        ST_T2_MUL,
        ST_T2_DIV,
        ST_SUM,
        ST_M_NUM,
        ST_M_DEN,
        ST_CHECK_RD,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_A,
        PH_B,
        PH_FIX,
        PH_LCM,
        PH_R
    } phase_t;

endpackage
`default_nettype wire

>>> sv/rau_unit.sv
// Iterative shared multiply / truncating divide / remainder unit, one bit per cycle.
`default_nettype none
module rau_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire unit_req_t         req,
    input  wire logic [WIDTH-1:0]  x,
    input  wire logic [WIDTH-1:0]  y,
    output logic [WIDTH-1:0]       res,
    output logic                   done
);

    localparam int CW = $clog2(WIDTH + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    unit_op_t          op_reg, op_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic [WIDTH-1:0]  a_reg, a_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic [WIDTH-1:0]  q_reg, q_next;
    logic [WIDTH-1:0]  res_reg, res_next;
    logic [WIDTH-1:0]  xmag, ymag;
    logic [WIDTH-1:0]  rsh;
    logic [WIDTH:0]    diff;
    logic [WIDTH-1:0]  a_step, q_step;

    assign xmag = x[WIDTH-1] ? (~x + WIDTH'(1)) : x;
    assign ymag = y[WIDTH-1] ? (~y + WIDTH'(1)) : y;
    assign rsh  = {a_reg[WIDTH-2:0], q_reg[WIDTH-1]};
    assign diff = {1'b0, rsh} - {1'b0, b_reg};

    always_comb
    begin
        if (op_reg == UOP_MUL)
        begin
            a_step = a_reg + (q_reg[0] ? b_reg : '0);
            q_step = {1'b0, q_reg[WIDTH-1:1]};
        end
        else
        begin
            a_step = diff[WIDTH] ? rsh : diff[WIDTH-1:0];
            q_step = {q_reg[WIDTH-2:0], ~diff[WIDTH]};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        if (!busy_reg && req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            op_next   = req.op;
            a_next    = '0;
            if (req.op == UOP_MUL)
            begin
                b_next = x;
                q_next = y;
            end
            else
            begin
                b_next = ymag;
                q_next = xmag;
            end
            negq_next = x[WIDTH-1] ^ y[WIDTH-1];
            negr_next = x[WIDTH-1];
        end
        else if (busy_reg)
        begin
            a_next   = a_step;
            q_next   = q_step;
            b_next   = (op_reg == UOP_MUL) ? {b_reg[WIDTH-2:0], 1'b0} : b_reg;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                case (op_reg)
                    UOP_MUL: res_next = a_step;
                    UOP_DIV: res_next = negq_reg ? (~q_step + WIDTH'(1)) : q_step;
                    default: res_next = negr_reg ? (~a_step + WIDTH'(1)) : a_step;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while still busy");
    a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with an empty bit count");

endmodule
`default_nettype wire

>>> sv/rational_arithmetic_unit.sv
// Top level: rational add, subtract, multiply and divide with gcd reduction.
// One item is taken at a time; in_ready is high only while the block is idle and the
// result item is held on out until it is taken. All multiplies, divides and remainders
// run through one shared bit-serial unit; the time an item takes is set by the number
// of unit operations, which follows the Euclid remainder steps of the three or four
// gcd reductions (and the lcm gcd for add and subtract).
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic              issued_reg, issued_next;
    logic [1:0]        func_reg, func_next;
    logic              err_reg, err_next;
    logic [WIDTH-1:0]  an_reg, an_next, ad_reg, ad_next;
    logic [WIDTH-1:0]  bn_reg, bn_next, bd_reg, bd_next;
    logic [WIDTH-1:0]  pn_reg, pn_next, pd_reg, pd_next;
    logic [WIDTH-1:0]  gx_reg, gx_next, gy_reg, gy_next;
    logic [WIDTH-1:0]  g_reg, g_next, t_reg, t_next, l_reg, l_next;
    logic [WIDTH-1:0]  rn_reg, rn_next, rd_reg, rd_next;
    unit_req_t         ureq;
    logic [WIDTH-1:0]  ux, uy, ures;
    logic              udone;
    logic              op_state;

    function automatic logic [WIDTH-1:0] from_in(input logic [31:0] v);
        logic [63:0] e;
        e = {{32{v[31]}}, v};
        return e[WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [WIDTH-1:0] v);
        logic [63:0] e;
        e = 64'(signed'(v));
        return e[31:0];
    endfunction

    rau_unit #(.WIDTH(WIDTH)) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .x     (ux),
        .y     (uy),
        .res   (ures),
        .done  (udone)
    );

    always_comb
    begin
        op_state = 1'b1;
        ureq.op  = UOP_MUL;
        ux       = an_reg;
        uy       = bn_reg;
        unique case (state_reg)
            ST_GCD_REM:  begin ureq.op = UOP_REM; ux = gx_reg; uy = gy_reg; end
            ST_RED_DIVN: begin ureq.op = UOP_DIV; ux = pn_reg; uy = g_reg;  end
            ST_RED_DIVD: begin ureq.op = UOP_DIV; ux = pd_reg; uy = g_reg;  end
            ST_L_MUL:    begin ureq.op = UOP_MUL; ux = ad_reg; uy = bd_reg; end
            ST_L_DIV:    begin ureq.op = UOP_DIV; ux = t_reg;  uy = g_reg;  end
            ST_T1_MUL:   begin ureq.op = UOP_MUL; ux = an_reg; uy = l_reg;  end
            ST_T1_DIV:   begin ureq.op = UOP_DIV; ux = t_reg;  uy = ad_reg; end
            ST_T2_MUL:   begin ureq.op = UOP_MUL; ux = bn_reg; uy = l_reg;  end
            ST_T2_DIV:   begin ureq.op = UOP_DIV; ux = t_reg;  uy = bd_reg; end
            ST_M_NUM:    begin ureq.op = UOP_MUL; ux = an_reg; uy = bn_reg; end
            ST_M_DEN:    begin ureq.op = UOP_MUL; ux = ad_reg; uy = bd_reg; end
            default:     op_state = 1'b0;
        endcase
        ureq.start  = op_state && !issued_reg;
        issued_next = op_state && !udone;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (ad_reg == '0 || bd_reg == '0 || (func_reg == FUNC_DIV && bn_reg == '0))
                    state_next = ST_DONE;
                else
                    state_next = ST_LD_A;
            ST_LD_A:
            begin
                phase_next = PH_A;
                state_next = ST_GCD_REM;
            end
            ST_LD_B:
            begin
                phase_next = PH_B;
                state_next = ST_GCD_REM;
            end
            ST_LD_FIX:
            begin
                phase_next = PH_FIX;
                state_next = ST_GCD_REM;
            end
            ST_L_INIT:
            begin
                phase_next = PH_LCM;
                state_next = ST_GCD_REM;
            end
            ST_GCD_REM:
                if (udone && ures == '0)
                begin
                    if (phase_reg == PH_LCM)
                        state_next = ST_L_MUL;
                    else if (gy_reg == WIDTH'(1))
                        state_next = ST_WB;
                    else
                        state_next = ST_RED_DIVN;
                end
            ST_RED_DIVN: if (udone) state_next = ST_RED_DIVD;
            ST_RED_DIVD: if (udone) state_next = ST_WB;
            ST_WB:
                unique case (phase_reg)
                    PH_A: state_next = ST_LD_B;
                    PH_B:
                        if (func_reg == FUNC_SUB || func_reg == FUNC_DIV)
                            state_next = ST_LD_FIX;
                        else if (func_reg == FUNC_ADD)
                            state_next = ST_L_INIT;
                        else
                            state_next = ST_M_NUM;
                    PH_FIX:
                        state_next = (func_reg == FUNC_SUB) ? ST_L_INIT : ST_M_NUM;
                    default: state_next = ST_DONE;
                endcase
            ST_L_MUL:  if (udone) state_next = ST_L_DIV;
            ST_L_DIV:  if (udone) state_next = ST_T1_MUL;
            ST_T1_MUL: if (udone) state_next = ST_T1_DIV;
            ST_T1_DIV: if (udone) state_next = ST_T2_MUL;
            ST_T2_MUL: if (udone) state_next = ST_T2_DIV;
            ST_T2_DIV: if (udone) state_next = ST_SUM;
            ST_SUM:    state_next = ST_CHECK_RD;
            ST_M_NUM:  if (udone) state_next = ST_M_DEN;
            ST_M_DEN:  if (udone) state_next = ST_CHECK_RD;
            ST_CHECK_RD:
            begin
                phase_next = PH_R;
                state_next = (rd_reg == '0) ? ST_DONE : ST_GCD_REM;
            end
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        func_next = func_reg;
        err_next  = err_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        pn_next = pn_reg; pd_next = pd_reg; gx_next = gx_reg; gy_next = gy_reg;
        g_next  = g_reg;  t_next  = t_reg;  l_next  = l_reg;
        rn_next = rn_reg; rd_next = rd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                func_next = in_data.func;
                an_next   = from_in(in_data.a_num);
                ad_next   = from_in(in_data.a_den);
                bn_next   = from_in(in_data.b_num);
                bd_next   = from_in(in_data.b_den);
                err_next  = 1'b1;
            end
            ST_CHECK:
                err_next = ad_reg == '0 || bd_reg == '0 ||
                           (func_reg == FUNC_DIV && bn_reg == '0);
            ST_LD_A:
            begin
                pn_next = an_reg; pd_next = ad_reg;
                gx_next = an_reg; gy_next = ad_reg;
            end
            ST_LD_B:
            begin
                pn_next = bn_reg; pd_next = bd_reg;
                gx_next = bn_reg; gy_next = bd_reg;
            end
            ST_LD_FIX:
                if (func_reg == FUNC_SUB)
                begin
                    pn_next = ~bn_reg + WIDTH'(1); pd_next = bd_reg;
                    gx_next = ~bn_reg + WIDTH'(1); gy_next = bd_reg;
                end
                else
                begin
                    pn_next = bd_reg; pd_next = bn_reg;
                    gx_next = bd_reg; gy_next = bn_reg;
                end
            ST_L_INIT:
            begin
                gx_next = ad_reg; gy_next = bd_reg;
            end
            ST_GCD_REM:
                if (udone)
                begin
                    gx_next = gy_reg;
                    gy_next = ures;
                    g_next  = gy_reg;
                end
            ST_RED_DIVN: if (udone) pn_next = ures;
            ST_RED_DIVD: if (udone) pd_next = ures;
            ST_WB:
                case (phase_reg)
                    PH_A:    begin an_next = pn_reg; ad_next = pd_reg; end
                    PH_B,
                    PH_FIX:  begin bn_next = pn_reg; bd_next = pd_reg; end
                    default: begin rn_next = pn_reg; rd_next = pd_reg; end
                endcase
            ST_L_MUL:  if (udone) t_next  = ures;
            ST_L_DIV:  if (udone) l_next  = ures;
            ST_T1_MUL: if (udone) t_next  = ures;
            ST_T1_DIV: if (udone) rn_next = ures;
            ST_T2_MUL: if (udone) t_next  = ures;
            ST_T2_DIV: if (udone) t_next  = ures;
            ST_SUM:
            begin
                rn_next = rn_reg + t_reg;
                rd_next = l_reg;
            end
            ST_M_NUM:  if (udone) rn_next = ures;
            ST_M_DEN:  if (udone) rd_next = ures;
            ST_CHECK_RD:
            begin
                err_next = rd_reg == '0;
                pn_next = rn_reg; pd_next = rd_reg;
                gx_next = rn_reg; gy_next = rd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_A;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        err_reg  <= err_next;
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        pn_reg <= pn_next; pd_reg <= pd_next; gx_reg <= gx_next; gy_reg <= gy_next;
        g_reg  <= g_next;  t_reg  <= t_next;  l_reg  <= l_next;
        rn_reg <= rn_next; rd_reg <= rd_next;
    end

    always_comb
    begin
        in_ready         = state_reg == ST_IDLE;
        out_valid        = state_reg == ST_DONE;
        out_data.error   = err_reg;
        out_data.res_num = err_reg ? '0 : to_out(rn_reg);
        out_data.res_den = err_reg ? '0 : to_out(rd_reg);
    end

    a_ready_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("idle while a result item waits");
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        ureq.start |-> !op_state || !issued_reg)
        else $error("second start issued for one operation");
    a_done_from_op: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_CHECK || state_reg == ST_WB ||
                                   state_reg == ST_CHECK_RD))
        else $error("result item raised from an unexpected state");

endmodule
`default_nettype wire
